### sv/tafg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TLV authentication frame gate.
// No dependencies; imported by tlv_auth_frame_gate_core.
package tafg_pkg;

    // Verdict codes given with each frame result.
    typedef enum logic [1:0] {
        VC_ACCEPTED  = 2'd0,
        VC_TOO_SHORT = 2'd1,
        VC_NO_AUTH   = 2'd2,
        VC_BACKWARDS = 2'd3
    } t_verdict;

    // Parser phase within one TLV item.
    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2
    } t_phase;

    localparam logic [7:0] AUTH_TYPE_A = 8'hF0;
    localparam logic [7:0] AUTH_TYPE_B = 8'hF1;
    localparam logic [1:0] MIN_FRAME_LEN = 2'd2;

endpackage

### sv/tlv_auth_frame_gate_core.sv
`timescale 1ns / 1ps
// Top level of the TLV authentication frame gate: byte parser and verdict register.
// Depends on tafg_pkg.

// The block takes one frame byte per cycle while not stalled and gives one
// verdict item on the byte flagged as last. A byte passes through an input
// register and then one parse and verdict stage into the output register.
// With the output side taking every result, one byte is accepted in every
// cycle; a verdict still waiting in the output register holds back only the
// next last byte, and the bytes after it stall behind that. The stored
// version starts at zero after reset.
module tlv_auth_frame_gate_core #(
    parameter int VERSION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic [15:0]         i_frame_version,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_accepted,
    output tafg_pkg::t_verdict  o_verdict_code,
    output logic [15:0]         o_stored_version_out
);
    import tafg_pkg::*;

    // Only the low bits of the 16-bit version field are kept.
    localparam int VW = (VERSION_BITS < 16) ? VERSION_BITS : 16;

    // Input register.
    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_last;
    logic [VW-1:0]  r_in_ver;

    // Parse state.
    t_phase         r_phase, n_phase;
    logic [7:0]     r_type, n_type;
    logic [7:0]     r_left, n_left;
    logic [1:0]     r_cnt, n_cnt;
    logic           r_auth, n_auth;
    logic           r_stopped, n_stopped;
    logic [VW-1:0]  r_cur_ver, n_cur_ver;

    // Output register.
    logic           r_out_valid;
    t_verdict       r_code, n_code;
    logic [VW-1:0]  r_out_ver;

    logic out_free;
    logic s1_go;
    logic in_take;
    logic complete;
    logic [7:0] left_dec;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !s1_go;
    assign in_take  = i_valid && !o_stall;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_left    = r_left;
        n_auth    = r_auth;
        n_stopped = r_stopped;
        n_cnt     = r_cnt;
        n_cur_ver = r_cur_ver;
        n_code    = VC_ACCEPTED;
        complete  = 1'b0;

        if (!r_stopped) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_type  = r_in_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_left = r_in_byte;
                    if (r_in_byte == 8'd0) begin
                        complete = 1'b1;
                    end else begin
                        n_phase = PH_VAL;
                    end
                end
                default: begin
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        complete = 1'b1;
                    end
                end
            endcase
        end

        // The type byte is always held in r_type by the time an item completes.
        if (complete) begin
            n_phase = PH_TYPE;
            if (r_type == AUTH_TYPE_A || r_type == AUTH_TYPE_B) begin
                n_auth    = 1'b1;
                n_stopped = 1'b1;
            end
        end

        if (r_cnt < MIN_FRAME_LEN) begin
            n_cnt = r_cnt + 2'd1;
        end

        if (r_in_last) begin
            if (n_cnt < MIN_FRAME_LEN) begin
                n_code = VC_TOO_SHORT;
            end else if (!n_auth) begin
                n_code = VC_NO_AUTH;
            end else if (r_in_ver < r_cur_ver) begin
                n_code = VC_BACKWARDS;
            end else begin
                n_code    = VC_ACCEPTED;
                n_cur_ver = r_in_ver;
            end
            // A verdict closes the frame.
            n_phase   = PH_TYPE;
            n_type    = 8'd0;
            n_left    = 8'd0;
            n_cnt     = 2'd0;
            n_auth    = 1'b0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_TYPE;
            r_type      <= 8'd0;
            r_left      <= 8'd0;
            r_cnt       <= 2'd0;
            r_auth      <= 1'b0;
            r_stopped   <= 1'b0;
            r_cur_ver   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (s1_go) begin
                r_in_valid <= 1'b0;
            end

            if (s1_go) begin
                r_phase   <= n_phase;
                r_type    <= n_type;
                r_left    <= n_left;
                r_cnt     <= n_cnt;
                r_auth    <= n_auth;
                r_stopped <= n_stopped;
                r_cur_ver <= n_cur_ver;
            end

            if (s1_go && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
            r_in_ver  <= i_frame_version[VW-1:0];
        end
        if (s1_go && r_in_last) begin
            r_code    <= n_code;
            r_out_ver <= n_cur_ver;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_verdict_code       = r_code;
    assign o_accepted           = (r_code == VC_ACCEPTED);
    assign o_stored_version_out = 16'(r_out_ver);

    // The scan only stops on a completed authentication item.
    a_stop_needs_auth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_auth)
        else $error("scan stopped without an authentication item");

    // The byte counter saturates at the minimum frame length.
    a_cnt_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MIN_FRAME_LEN)
        else $error("byte counter past saturation");

    // A waiting verdict always reports the version currently stored.
    a_out_ver_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ver == r_cur_ver))
        else $error("reported version differs from stored version");

    // An accepted frame never moves the stored version backwards.
    a_ver_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in_last && n_code == VC_ACCEPTED) |-> (r_in_ver >= r_cur_ver))
        else $error("stored version moved backwards");

endmodule
